FILE: src/spag_pkg.sv
// ----------------------------------------------------------------------------
// spag_pkg
// Shared types, board constants and line attack functions for the sliding
// piece attack generator.
// ----------------------------------------------------------------------------
`default_nettype none

package spag_pkg;

	localparam int BoardW = 64;
	localparam int SquareW = 6;
	localparam int FuncW = 2;

	localparam int DefQueueDepth = 2;

	typedef logic [BoardW-1:0] board_t;

	localparam board_t FileABits = 64'h0101010101010101;
	localparam board_t Rank1Bits = 64'h00000000000000ff;
	localparam board_t MainDiag = 64'h8040201008040201;
	localparam board_t MainAntiDiag = 64'h0102040810204080;

	typedef enum logic [FuncW-1:0] {
		FUNC_ROOK = 2'd0,
		FUNC_BISHOP = 2'd1,
		FUNC_ROOK_XRAY = 2'd2,
		FUNC_BISHOP_XRAY = 2'd3
	} func_t;

	// Classified query: square bit, both lines of the slider, boards.
	typedef struct packed {
		logic xray;
		board_t sq_bit;
		board_t line_a;
		board_t line_b;
		board_t occupancy;
		board_t blockers;
	} job_t;

	function automatic board_t bit_rev(input board_t v);
		board_t r;
		for (int i = 0; i < BoardW; i++) begin
			r[i] = v[BoardW-1-i];
		end
		return r;
	endfunction

	// Hyperbola quintessence on one line; both subtractions run side by side.
	function automatic board_t line_attacks(input board_t sq_bit, input board_t occ,
			input board_t line);
		board_t o;
		board_t up;
		board_t down_r;
		o = occ & line;
		up = o - (sq_bit << 1);
		down_r = bit_rev(o) - (bit_rev(sq_bit) << 1);
		return (up ^ bit_rev(down_r)) & line;
	endfunction

endpackage

`default_nettype wire

FILE: src/spag_if.sv
// ----------------------------------------------------------------------------
// spag_req_if / spag_rsp_if
// Valid/ready channels for queries and attack results.
// ----------------------------------------------------------------------------
`default_nettype none

interface spag_req_if;
	logic valid;
	logic ready;
	logic [1:0] func;
	logic [5:0] square;
	logic [63:0] occupancy;
	logic [63:0] blockers;

	modport source(output valid, func, square, occupancy, blockers, input ready);
	modport sink(input valid, func, square, occupancy, blockers, output ready);
endinterface

interface spag_rsp_if;
	logic valid;
	logic ready;
	logic [63:0] attacks;

	modport source(output valid, attacks, input ready);
	modport sink(input valid, attacks, output ready);
endinterface

`default_nettype wire

FILE: src/spag_front.sv
// ----------------------------------------------------------------------------
// spag_front
// Accepts query beats, decodes the slider kind and builds its two line masks.
// ----------------------------------------------------------------------------
`default_nettype none

module spag_front import spag_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	spag_req_if.sink req,
	output logic push_valid,
	input wire logic push_ready,
	output job_t push_job
);

	logic valid_q;
	job_t job_q;
	job_t job_d;
	func_t func;
	logic bishop;
	logic [2:0] file;
	logic [2:0] rank;
	logic [3:0] diag_sum;
	board_t file_mask;
	board_t rank_mask;
	board_t diag_mask;
	board_t anti_mask;

	assign req.ready = !valid_q || push_ready;
	assign push_valid = valid_q;
	assign push_job = job_q;

	always_comb begin
		func = func_t'(req.func);
		bishop = (func == FUNC_BISHOP) || (func == FUNC_BISHOP_XRAY);
		file = req.square[2:0];
		rank = req.square[5:3];
		diag_sum = {1'b0, rank} + {1'b0, file};
		file_mask = FileABits << file;
		rank_mask = Rank1Bits << {rank, 3'b000};
		if (rank >= file) begin
			diag_mask = MainDiag << {3'(rank - file), 3'b000};
		end else begin
			diag_mask = MainDiag >> {3'(file - rank), 3'b000};
		end
		if (diag_sum >= 4'd7) begin
			anti_mask = MainAntiDiag << {3'(diag_sum - 4'd7), 3'b000};
		end else begin
			anti_mask = MainAntiDiag >> {3'(4'd7 - diag_sum), 3'b000};
		end
		job_d.xray = (func == FUNC_ROOK_XRAY) || (func == FUNC_BISHOP_XRAY);
		job_d.sq_bit = board_t'(1) << req.square;
		job_d.line_a = bishop ? diag_mask : file_mask;
		job_d.line_b = bishop ? anti_mask : rank_mask;
		job_d.occupancy = req.occupancy;
		job_d.blockers = req.blockers;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req.ready) begin
			valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			job_q <= job_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/spag_queue.sv
// ----------------------------------------------------------------------------
// spag_queue
// Short job queue between the decode front and the attack back end.
// ----------------------------------------------------------------------------
`default_nettype none

module spag_queue import spag_pkg::*; #(
	parameter int Depth = DefQueueDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	output logic push_ready,
	input wire job_t push_job,
	output logic pop_valid,
	input wire logic pop_ready,
	output job_t pop_job
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	job_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic push_fire;
	logic pop_fire;

	assign push_ready = count_q != CntW'(Depth);
	assign pop_valid = count_q != '0;
	assign pop_job = mem_q[rd_ptr_q];
	assign push_fire = push_valid && push_ready;
	assign pop_fire = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

FILE: src/spag_back.sv
// ----------------------------------------------------------------------------
// spag_back
// Two-stage attack pipeline: plain attack set, then the x-ray pass and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module spag_back import spag_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pop_valid,
	output logic pop_ready,
	input wire job_t pop_job,
	spag_rsp_if.source rsp
);

	logic valid_s1;
	job_t job_s1;
	board_t atk_s1;
	logic valid_s2;
	board_t attacks_s2;
	logic ready_s1;
	logic ready_s2;
	board_t atk_d;
	board_t occ_x;
	board_t atk_x;
	board_t result;

	assign ready_s2 = !valid_s2 || rsp.ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign pop_ready = ready_s1;
	assign rsp.valid = valid_s2;
	assign rsp.attacks = attacks_s2;

	always_comb begin
		atk_d = line_attacks(pop_job.sq_bit, pop_job.occupancy, pop_job.line_a)
			| line_attacks(pop_job.sq_bit, pop_job.occupancy, pop_job.line_b);
		// toggle the blockers that the first pass reached
		occ_x = job_s1.occupancy ^ (job_s1.blockers & atk_s1);
		atk_x = line_attacks(job_s1.sq_bit, occ_x, job_s1.line_a)
			| line_attacks(job_s1.sq_bit, occ_x, job_s1.line_b);
		result = job_s1.xray ? (atk_s1 ^ atk_x) : atk_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= pop_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop_valid && ready_s1) begin
			job_s1 <= pop_job;
			atk_s1 <= atk_d;
		end
		if (valid_s1 && ready_s2) begin
			attacks_s2 <= result;
		end
	end

endmodule

`default_nettype wire

FILE: src/sliding_piece_attack_generator.sv
// ----------------------------------------------------------------------------
// sliding_piece_attack_generator
// Rook and bishop attack sets, plain and x-ray, by hyperbola quintessence.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one query beat: func, square, occupancy and blockers.
//   rsp carries one beat per query with the 64-bit attacks board, in order.
//   Throughput: one query per cycle, sustained while rsp is taken.
//   A result beat is offered once its query beat has passed the decode
//   register, the queue, the plain-attack stage and the x-ray stage.
//   The x-ray pass depends on the plain attack set, which sets the two
//   back-end stages; each stage holds two 64-bit subtracts per line path.
//   Reset empties the decode register, the queue and the pipeline; no
//   beat is offered until a query arrives.
//   When rsp stalls, the back end holds its beats and the queue fills;
//   req.ready drops only once the decode register cannot drain into a
//   full queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_piece_attack_generator import spag_pkg::*; #(
	parameter int QueueDepth = DefQueueDepth
) (
	input wire logic clk,
	input wire logic arst_n,
	spag_req_if.sink req,
	spag_rsp_if.source rsp
);

	logic push_valid;
	logic push_ready;
	job_t push_job;
	logic pop_valid;
	logic pop_ready;
	job_t pop_job;

	spag_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job(push_job)
	);

	spag_queue #(
		.Depth(QueueDepth)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_job(push_job),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_job(pop_job)
	);

	spag_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_job(pop_job),
		.rsp(rsp)
	);

	// an accepted query sits in the decode register next cycle
	a_front_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> push_valid)
		else $error("accepted query missing from decode register");

	// a pushed job leaves the queue non-empty
	a_queue_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && push_ready) |=> pop_valid)
		else $error("queue empty after push");

	// a fresh result beat comes from a job popped through the plain-attack and x-ray stages
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(pop_valid && pop_ready, 2))
		else $error("result beat without a popped job");

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives rook and bishop attack queries (plain and x-ray) into the sliding
// piece attack generator with random gaps and response stalls. Every result
// beat is checked against a hyperbola quintessence predictor, or against the
// board typed into the directed table where it is obvious.
// ----------------------------------------------------------------------------

module tb_top;
	import spag_pkg::*;

	localparam int LimitCycles = 500000;
	localparam int RandomQueries = 900;
	localparam int DrainCycles = 8;
	localparam int DirectedN = 20;

	localparam board_t FileA = 64'h0101010101010101;
	localparam board_t Rank1 = 64'h00000000000000ff;
	localparam board_t DiagA1H8 = 64'h8040201008040201;
	localparam board_t DiagA8H1 = 64'h0102040810204080;
	localparam board_t AllSquares = 64'hffffffffffffffff;

	typedef struct {
		func_t func;
		logic [5:0] square;
		board_t occ;
		board_t blk;
		bit pinned;
		board_t want;
	} query_row_t;

	logic clk;
	logic arst_n;

	spag_req_if req_ch();
	spag_rsp_if rsp_ch();

	sliding_piece_attack_generator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	board_t attack_sets_due[$];
	int mismatches = 0;
	int cycles;
	bit pin_next;
	board_t pinned_attacks;

	// Corners, full boards, slider bit set or clear, blockers on empty squares.
	query_row_t directed_rows [DirectedN] = '{
		'{FUNC_ROOK, 6'd0, 64'h0, 64'h0, 1'b1, 64'h01010101010101fe},
		'{FUNC_BISHOP, 6'd0, 64'h0, 64'h0, 1'b1, 64'h8040201008040200},
		'{FUNC_ROOK, 6'd63, 64'h0, AllSquares, 1'b1, 64'h7f80808080808080},
		'{FUNC_BISHOP, 6'd63, 64'h0, 64'h0, 1'b1, 64'h0040201008040201},
		'{FUNC_BISHOP, 6'd56, 64'h0, 64'h0, 1'b1, 64'h0002040810204080},
		'{FUNC_ROOK, 6'd0, AllSquares, 64'h0, 1'b1, 64'h0000000000000102},
		'{FUNC_BISHOP, 6'd0, AllSquares, 64'h0, 1'b1, 64'h0000000000000200},
		'{FUNC_ROOK, 6'd27, AllSquares, 64'h0, 1'b1, 64'h0000000814080000},
		'{FUNC_ROOK_XRAY, 6'd27, 64'h00a0_0008_1400_2200, 64'h0, 1'b1, 64'h0},
		'{FUNC_BISHOP_XRAY, 6'd36, 64'h4422_0000_2841_0000, 64'h0, 1'b1, 64'h0},
		'{FUNC_ROOK, 6'd27, 64'h0000_0000_0800_0000, 64'h0, 1'b0, 64'h0},
		'{FUNC_ROOK, 6'd27, 64'h0000_0000_0000_0000, 64'h0, 1'b0, 64'h0},
		'{FUNC_BISHOP, 6'd7, 64'h0000_0000_0020_4080, 64'h0, 1'b0, 64'h0},
		'{FUNC_ROOK_XRAY, 6'd0, 64'h0, AllSquares, 1'b0, 64'h0},
		'{FUNC_BISHOP_XRAY, 6'd27, AllSquares, AllSquares, 1'b0, 64'h0},
		'{FUNC_ROOK_XRAY, 6'd35, 64'h0808_0036_0008_0808, 64'h0808_0036_0008_0808, 1'b0,
			64'h0},
		'{FUNC_BISHOP_XRAY, 6'd0, 64'h0000_0000_0004_0200, 64'h200, 1'b0, 64'h0},
		'{FUNC_ROOK, 6'd7, 64'h8000_0000_0000_0001, AllSquares, 1'b0, 64'h0},
		'{FUNC_BISHOP, 6'd63, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0, 64'h0},
		'{FUNC_ROOK_XRAY, 6'd63, AllSquares, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, 64'h0}
	};

	// Reverse all 64 bits by bit, pair, nibble, byte and halfword swaps.
	function automatic board_t mirror_board(input board_t v);
		board_t r;
		r = ((v & 64'h5555555555555555) << 1) | ((v >> 1) & 64'h5555555555555555);
		r = ((r & 64'h3333333333333333) << 2) | ((r >> 2) & 64'h3333333333333333);
		r = ((r & 64'h0f0f0f0f0f0f0f0f) << 4) | ((r >> 4) & 64'h0f0f0f0f0f0f0f0f);
		r = ((r & 64'h00ff00ff00ff00ff) << 8) | ((r >> 8) & 64'h00ff00ff00ff00ff);
		return (r << 48) | ((r & 64'hffff0000) << 16) | ((r >> 16) & 64'hffff0000) |
			(r >> 48);
	endfunction

	function automatic board_t line_hits(input logic [5:0] sq, input board_t occ,
			input board_t line);
		board_t s;
		board_t o;
		board_t up;
		board_t down;
		s = board_t'(1) << sq;
		o = occ & line;
		up = o - (s << 1);
		down = mirror_board(mirror_board(o) - (mirror_board(s) << 1));
		return (up ^ down) & line;
	endfunction

	function automatic board_t slider_reach(input bit bishop, input logic [5:0] sq,
			input board_t occ);
		int f_idx;
		int r_idx;
		board_t diag;
		board_t anti;
		f_idx = sq[2:0];
		r_idx = sq[5:3];
		if (!bishop) begin
			return line_hits(sq, occ, FileA << f_idx) | line_hits(sq, occ, Rank1 << (8 * r_idx));
		end
		if (r_idx >= f_idx) begin
			diag = DiagA1H8 << (8 * (r_idx - f_idx));
		end else begin
			diag = DiagA1H8 >> (8 * (f_idx - r_idx));
		end
		if (r_idx + f_idx >= 7) begin
			anti = DiagA8H1 << (8 * (r_idx + f_idx - 7));
		end else begin
			anti = DiagA8H1 >> (8 * (7 - r_idx - f_idx));
		end
		return line_hits(sq, occ, diag) | line_hits(sq, occ, anti);
	endfunction

	function automatic board_t predict_attacks(input func_t f, input logic [5:0] sq,
			input board_t occ, input board_t blk);
		bit bishop;
		board_t atk;
		bishop = (f == FUNC_BISHOP) || (f == FUNC_BISHOP_XRAY);
		atk = slider_reach(bishop, sq, occ);
		// x-ray: toggle the blockers that are hit, keep only the change
		if (f == FUNC_ROOK_XRAY || f == FUNC_BISHOP_XRAY) begin
			atk ^= slider_reach(bishop, sq, occ ^ (blk & atk));
		end
		return atk;
	endfunction

	// Mostly short gaps, some medium, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 8);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic board_t random_board();
		board_t b;
		case ($urandom_range(0, 7))
			0, 1: b = {$urandom, $urandom};
			2, 3, 4: b = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			5: b = {$urandom, $urandom} & {$urandom, $urandom};
			6: b = {$urandom, $urandom} | {$urandom, $urandom};
			default: begin
				b = '0;
				repeat ($urandom_range(0, 4)) b[$urandom_range(0, 63)] = 1'b1;
			end
		endcase
		return b;
	endfunction

	task automatic send_query(input func_t f, input logic [5:0] sq, input board_t occ,
			input board_t blk, input bit pin, input board_t want, input int gap);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.func <= f;
		req_ch.square <= sq;
		req_ch.occupancy <= occ;
		req_ch.blockers <= blk;
		pin_next <= pin;
		pinned_attacks <= want;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		cycles = 0;
		while (cycles < LimitCycles) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Record the expected board for each accepted query beat.
	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready) begin
			if (pin_next) begin
				attack_sets_due.push_back(pinned_attacks);
			end else begin
				attack_sets_due.push_back(predict_attacks(func_t'(req_ch.func),
					req_ch.square, req_ch.occupancy, req_ch.blockers));
			end
		end
	end

	always @(posedge clk) begin : check_attacks
		board_t due;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (attack_sets_due.size() == 0) begin
				$error("attacks: beat with no query outstanding, actual %h", rsp_ch.attacks);
				mismatches++;
			end else begin
				due = attack_sets_due.pop_front();
				if (rsp_ch.attacks !== due) begin
					$error("attacks: expected %h, actual %h", due, rsp_ch.attacks);
					mismatches++;
				end
			end
		end
	end

	// Result side: random stalls, with every fifth stretch left open.
	initial begin : drive_ready
		int stall;
		int round;
		rsp_ch.ready = 1'b0;
		round = 0;
		@(posedge clk);
		forever begin
			stall = pick_gap();
			round++;
			if (stall > 0 && (round / 40) % 5 != 4) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	initial begin : stimulus
		func_t f;
		board_t occ;
		board_t blk;
		int gap;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_ROOK;
		req_ch.square = '0;
		req_ch.occupancy = '0;
		req_ch.blockers = '0;
		pin_next = 1'b0;
		pinned_attacks = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_query(directed_rows[i].func, directed_rows[i].square, directed_rows[i].occ,
				directed_rows[i].blk, directed_rows[i].pinned, directed_rows[i].want,
				pick_gap());
		end

		for (int k = 0; k < RandomQueries; k++) begin
			f = func_t'($urandom_range(0, 3));
			occ = random_board();
			case ($urandom_range(0, 5))
				0: blk = {$urandom, $urandom};
				1: blk = AllSquares;
				2: blk = '0;
				default: blk = occ & {$urandom, $urandom};
			endcase
			// hold back-to-back beats through a quiet stretch now and then
			gap = ((k / 64) % 4 == 3) ? 0 : pick_gap();
			send_query(f, 6'($urandom_range(0, 63)), occ, blk, 1'b0, '0, gap);
		end
		req_ch.valid <= 1'b0;
		// let the last accepted beat land in the expected queue
		@(posedge clk);

		while (attack_sets_due.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

FILE: filelist.f
src/spag_pkg.sv
src/spag_if.sv
src/spag_front.sv
src/spag_queue.sv
src/spag_back.sv
src/sliding_piece_attack_generator.sv
test/tb_top.sv
